/* design/tvd_slope_limiter_macros.svh */
// Assertion shorthands used by the checker file of the slope limiter.
`ifndef TVD_SLOPE_LIMITER_MACROS_SVH
`define TVD_SLOPE_LIMITER_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off while in reset.
`define TVD_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tvd_slope_limiter check failed");

// Next-cycle implication, sampled on the block clock, off while in reset.
`define TVD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tvd_slope_limiter check failed");

`endif

/* design/tvd_pkg.sv */
`timescale 1ns / 1ps
package tvd_pkg;
    localparam int VALUE_W    = 32;
    localparam int DIFF_W     = VALUE_W + 1;
    localparam int SUM_W      = DIFF_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int THETA_W    = 18;
    localparam int THETA_FRAC = 16;
    localparam int TPROD_W    = THETA_W + DIFF_W;
    localparam int SPAN_SH_W  = DIFF_W + THETA_FRAC - 1;
    localparam int EPS_W      = 16;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int QUO_W      = 33;
    localparam int PL_W       = SUM_W + DIFF_W;
    localparam int NUM_W      = PL_W + DIFF_W;
    localparam int DEN_W      = PROD_W + 2;
    localparam int REM_W      = NUM_W + 1;
    localparam int MAG_W      = QUO_W + 1;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    localparam logic [MODE_W-1:0] MODE_NONE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_VANLEER = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MINMOD  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MC      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GMINMOD = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ALBADA  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THETA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS   = 2'd2;

    localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_GMINMOD;
    localparam logic [THETA_W-1:0] THETA_RESET = 18'd98304;
    localparam logic [EPS_W-1:0]   EPS_RESET   = 16'd1;
    localparam logic [THETA_W-1:0] THETA_MC    = 18'd131072;

    typedef enum logic [2:0] {
        K_ZERO,
        K_FLAG,
        K_HALFMIN,
        K_THETA,
        K_VANLEER,
        K_ALBADA
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic                neg;
        logic [DIFF_W-1:0]   mag_a;
        logic [DIFF_W-1:0]   mag_b;
        logic [DIFF_W-1:0]   mag_span;
        logic [THETA_W-1:0]  theta;
    } t_job;
endpackage

/* design/tvd_front.sv */
`timescale 1ns / 1ps
module tvd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [tvd_pkg::VALUE_W-1:0]    i_left,
    input  logic [tvd_pkg::VALUE_W-1:0]    i_center,
    input  logic [tvd_pkg::VALUE_W-1:0]    i_right,
    input  logic [tvd_pkg::MODE_W-1:0]     i_mode,
    input  logic [tvd_pkg::THETA_W-1:0]    i_theta,
    input  logic [tvd_pkg::EPS_W-1:0]      i_eps,
    output logic                           o_valid,
    input  logic                           i_ready,
    output tvd_pkg::t_job                  o_job
);
    import tvd_pkg::*;

    logic [DIFF_W-1:0] dl, dr, span;
    logic              dl_pos, dl_neg, dr_pos, dr_neg, same, opposite;
    t_job              n_job, r_job;
    logic              r_valid;

    assign dl   = {i_center[VALUE_W-1], i_center} - {i_left[VALUE_W-1], i_left};
    assign dr   = {i_right[VALUE_W-1], i_right} - {i_center[VALUE_W-1], i_center};
    assign span = {i_right[VALUE_W-1], i_right} - {i_left[VALUE_W-1], i_left};

    assign dl_neg   = dl[DIFF_W-1];
    assign dr_neg   = dr[DIFF_W-1];
    assign dl_pos   = !dl_neg && (dl != '0);
    assign dr_pos   = !dr_neg && (dr != '0);
    assign same     = (dl_pos && dr_pos) || (dl_neg && dr_neg);
    assign opposite = (dl_pos && dr_neg) || (dl_neg && dr_pos);

    always_comb begin
        n_job          = '0;
        n_job.kind     = K_ZERO;
        n_job.mag_a    = dl_neg ? -dl : dl;
        n_job.mag_b    = dr_neg ? -dr : dr;
        n_job.mag_span = span[DIFF_W-1] ? -span : span;
        n_job.theta    = (i_mode == MODE_MC) ? THETA_MC : i_theta;
        unique case (i_mode)
            MODE_VANLEER: begin
                if (span == '0) begin
                    n_job.kind = K_FLAG;
                end else if (same) begin
                    n_job.kind = K_VANLEER;
                    n_job.neg  = dl_neg;
                end
            end
            MODE_MINMOD: begin
                if (same) begin
                    n_job.kind = K_HALFMIN;
                    n_job.neg  = dl_neg;
                end
            end
            MODE_MC, MODE_GMINMOD: begin
                if (!opposite) begin
                    n_job.kind = K_THETA;
                    n_job.neg  = span[DIFF_W-1];
                end
            end
            MODE_ALBADA: begin
                if (!opposite) begin
                    // A flat stencil with zero epsilon leaves nothing to divide by.
                    if (dl == '0 && dr == '0 && i_eps == '0) begin
                        n_job.kind = K_FLAG;
                    end else begin
                        n_job.kind = K_ALBADA;
                        n_job.neg  = dl_neg || dr_neg;
                    end
                end
            end
            default: n_job.kind = K_ZERO;
        endcase
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end
endmodule

/* design/tvd_queue.sv */
`timescale 1ns / 1ps
module tvd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tvd_pkg::t_job  i_job,
    output logic           o_valid,
    input  logic           i_pop,
    output tvd_pkg::t_job  o_job
);
    import tvd_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              push, pop;

    assign o_ready = (r_cnt != QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_job;
        end
    end
endmodule

/* design/tvd_back.sv */
`timescale 1ns / 1ps
module tvd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_pop,
    input  tvd_pkg::t_job                  i_job,
    input  logic [tvd_pkg::EPS_W-1:0]      i_eps,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [tvd_pkg::VALUE_W-1:0]    o_half,
    output logic                           o_flag
);
    import tvd_pkg::*;

    localparam logic [MAG_W-1:0] MAX_POS = MAG_W'((64'd1 << (VALUE_W - 1)) - 64'd1);
    localparam logic [MAG_W-1:0] MAX_NEG = MAG_W'(64'd1 << (VALUE_W - 1));

    logic adv;

    // Stage 1: products, sum and half minimum of the magnitudes.
    logic                 r1_valid;
    t_kind                r1_kind;
    logic                 r1_neg;
    logic [PROD_W-1:0]    r1_ab, r1_aa, r1_bb;
    logic [TPROD_W-1:0]   r1_ta, r1_tb;
    logic [SPAN_SH_W-1:0] r1_xs;
    logic [SUM_W-1:0]     r1_s;
    logic [DIFF_W-1:0]    r1_hm;

    // Stage 2: partial products of the van Albada numerator, direct results.
    logic                 r2_valid;
    t_kind                r2_kind;
    logic                 r2_neg;
    logic [MAG_W-1:0]     r2_direct;
    logic [PL_W-1:0]      r2_pl, r2_ph;
    logic [DEN_W-1:0]     r2_d2;
    logic [PROD_W-1:0]    r2_ab;
    logic [SUM_W-1:0]     r2_s;

    // Stage 3: dividend and divisor.
    logic                 r3_valid;
    t_kind                r3_kind;
    logic                 r3_neg;
    logic [MAG_W-1:0]     r3_direct;
    logic [NUM_W-1:0]     r3_num;
    logic [DEN_W-1:0]     r3_den;

    // Divider stages, one quotient bit each, most significant first.
    logic                 r_dv_valid  [QUO_W];
    t_kind                r_dv_kind   [QUO_W];
    logic                 r_dv_neg    [QUO_W];
    logic [MAG_W-1:0]     r_dv_direct [QUO_W];
    logic [NUM_W-1:0]     r_dv_rem    [QUO_W];
    logic [DEN_W-1:0]     r_dv_den    [QUO_W];
    logic [QUO_W-1:0]     r_dv_q      [QUO_W];

    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_half;
    logic                 r_flag;

    assign adv   = !r_out_valid || i_ready;
    assign o_pop = adv && i_valid;

    logic [PROD_W-1:0]  p;
    logic [DEN_W-1:0]   d_sum;
    logic [TPROD_W-1:0] t_min;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_kind <= i_job.kind;
            r1_neg  <= i_job.neg;
            r1_ab   <= PROD_W'(i_job.mag_a) * PROD_W'(i_job.mag_b);
            r1_aa   <= PROD_W'(i_job.mag_a) * PROD_W'(i_job.mag_a);
            r1_bb   <= PROD_W'(i_job.mag_b) * PROD_W'(i_job.mag_b);
            r1_ta   <= TPROD_W'(i_job.theta) * TPROD_W'(i_job.mag_a);
            r1_tb   <= TPROD_W'(i_job.theta) * TPROD_W'(i_job.mag_b);
            r1_xs   <= {i_job.mag_span, {(THETA_FRAC - 1){1'b0}}};
            r1_s    <= SUM_W'(i_job.mag_a) + SUM_W'(i_job.mag_b);
            r1_hm   <= (i_job.mag_a < i_job.mag_b) ? (i_job.mag_a >> 1) : (i_job.mag_b >> 1);
        end
    end

    always_comb begin
        p     = r1_ab + PROD_W'(i_eps);
        d_sum = (DEN_W'(r1_aa) + DEN_W'(r1_bb) + (DEN_W'(i_eps) << 1)) << 1;
        t_min = TPROD_W'(r1_xs);
        if (r1_ta < t_min) begin
            t_min = r1_ta;
        end
        if (r1_tb < t_min) begin
            t_min = r1_tb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_kind <= r1_kind;
            r2_neg  <= r1_neg;
            r2_pl   <= PL_W'(r1_s) * PL_W'(p[DIFF_W-1:0]);
            r2_ph   <= PL_W'(r1_s) * PL_W'(p[PROD_W-1:DIFF_W]);
            r2_d2   <= d_sum;
            r2_ab   <= r1_ab;
            r2_s    <= r1_s;
            priority case (r1_kind)
                K_THETA:   r2_direct <= MAG_W'(t_min >> (THETA_FRAC + 1));
                K_HALFMIN: r2_direct <= MAG_W'(r1_hm);
                default:   r2_direct <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_kind   <= r2_kind;
            r3_neg    <= r2_neg;
            r3_direct <= r2_direct;
            priority case (r2_kind)
                K_ALBADA: begin
                    r3_num <= NUM_W'(r2_pl) + {r2_ph, {DIFF_W{1'b0}}};
                    r3_den <= r2_d2;
                end
                K_VANLEER: begin
                    r3_num <= NUM_W'(r2_ab);
                    r3_den <= DEN_W'(r2_s);
                end
                default: begin
                    r3_num <= '0;
                    r3_den <= DEN_W'(1);
                end
            endcase
        end
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        localparam int SH = QUO_W - 1 - k;
        logic             in_valid, in_neg;
        t_kind            in_kind;
        logic [MAG_W-1:0] in_direct;
        logic [NUM_W-1:0] in_rem;
        logic [DEN_W-1:0] in_den;
        logic [QUO_W-1:0] in_q, n_q;
        logic [REM_W-1:0] trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign in_valid  = r3_valid;
            assign in_kind   = r3_kind;
            assign in_neg    = r3_neg;
            assign in_direct = r3_direct;
            assign in_rem    = r3_num;
            assign in_den    = r3_den;
            assign in_q      = '0;
        end else begin : g_next
            assign in_valid  = r_dv_valid[k-1];
            assign in_kind   = r_dv_kind[k-1];
            assign in_neg    = r_dv_neg[k-1];
            assign in_direct = r_dv_direct[k-1];
            assign in_rem    = r_dv_rem[k-1];
            assign in_den    = r_dv_den[k-1];
            assign in_q      = r_dv_q[k-1];
        end

        always_comb begin
            trial   = REM_W'(in_rem) - (REM_W'(in_den) << SH);
            ge      = !trial[REM_W-1];
            n_q     = in_q;
            n_q[SH] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[k] <= 1'b0;
            end else if (adv) begin
                r_dv_valid[k] <= in_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_kind[k]   <= in_kind;
                r_dv_neg[k]    <= in_neg;
                r_dv_direct[k] <= in_direct;
                r_dv_rem[k]    <= ge ? trial[NUM_W-1:0] : in_rem;
                r_dv_den[k]    <= in_den;
                r_dv_q[k]      <= n_q;
            end
        end
    end

    logic [MAG_W-1:0]   mag;
    logic [VALUE_W-1:0] n_half;

    always_comb begin
        if (r_dv_kind[QUO_W-1] == K_VANLEER || r_dv_kind[QUO_W-1] == K_ALBADA) begin
            mag = {1'b0, r_dv_q[QUO_W-1]};
        end else begin
            mag = r_dv_direct[QUO_W-1];
        end
        if (mag == '0) begin
            n_half = '0;
        end else if (r_dv_neg[QUO_W-1]) begin
            n_half = (mag > MAX_NEG) ? -MAX_NEG[VALUE_W-1:0] : -mag[VALUE_W-1:0];
        end else begin
            n_half = (mag > MAX_POS) ? MAX_POS[VALUE_W-1:0] : mag[VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r1_valid    <= i_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_out_valid <= r_dv_valid[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_half <= n_half;
            r_flag <= (r_dv_kind[QUO_W-1] == K_FLAG);
        end
    end

    assign o_valid = r_out_valid;
    assign o_half  = r_half;
    assign o_flag  = r_flag;
endmodule

/* design/tvd_slope_limiter.sv */
`timescale 1ns / 1ps
// Channel     Direction  Payload (low bit first)
// s_axis_*    in         tdata: left_value, center_value, right_value
// m_axis_*    out        tdata: half_slope; tuser: degenerate_flag
// i_cfg_*     in         index 0 limiter_mode, 1 theta_gain, 2 albada_epsilon
//
// One stencil is accepted per cycle unless a stalled output has filled the queue.
// The result passes through the pipelined restoring divider, one quotient bit per stage.
// Reset (synchronous, active low) empties the pipeline and restores the registers.
// An output stall freezes the back pipeline; the front accepts until the queue fills.
module tvd_slope_limiter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // left_value [31:0], center_value [63:32], right_value [95:64]
    input  logic [3*tvd_pkg::VALUE_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // half_slope [31:0]
    output logic [tvd_pkg::VALUE_W-1:0]       m_axis_tdata,
    // degenerate_flag [0]
    output logic [0:0]                        m_axis_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tvd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tvd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import tvd_pkg::*;

    logic [MODE_W-1:0]  r_mode;
    logic [THETA_W-1:0] r_theta;
    logic [EPS_W-1:0]   r_eps;

    // The configuration port never stalls; an index past the list is dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_RESET;
            r_theta <= THETA_RESET;
            r_eps   <= EPS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:  r_mode  <= i_cfg_data[MODE_W-1:0];
                CFG_THETA: r_theta <= i_cfg_data[THETA_W-1:0];
                CFG_EPS:   r_eps   <= i_cfg_data[EPS_W-1:0];
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    logic front_valid, queue_ready, queue_valid, pop;
    t_job front_job, queue_job;

    // The front computes the differences and reduces each request to one job kind.
    tvd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_left   (s_axis_tdata[VALUE_W-1:0]),
        .i_center (s_axis_tdata[2*VALUE_W-1:VALUE_W]),
        .i_right  (s_axis_tdata[3*VALUE_W-1:2*VALUE_W]),
        .i_mode   (r_mode),
        .i_theta  (r_theta),
        .i_eps    (r_eps),
        .o_valid  (front_valid),
        .i_ready  (queue_ready),
        .o_job    (front_job)
    );

    tvd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (queue_ready),
        .i_job   (front_job),
        .o_valid (queue_valid),
        .i_pop   (pop),
        .o_job   (queue_job)
    );

    // The back multiplies, divides and saturates, and holds the output register.
    tvd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .o_pop   (pop),
        .i_job   (queue_job),
        .i_eps   (r_eps),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_half  (m_axis_tdata),
        .o_flag  (m_axis_tuser[0])
    );
endmodule

/* design/tvd_checker.sv */
`timescale 1ns / 1ps
`include "tvd_slope_limiter_macros.svh"
module tvd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [tvd_pkg::VALUE_W-1:0]       m_axis_tdata,
    input logic [0:0]                        m_axis_tuser
);
    // A stalled result stays offered and unchanged.
    `TVD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `TVD_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    // A degenerate division always reports a zero slope.
    `TVD_ASSERT_IMPL(a_flag_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)
    // Leaving reset, the pipeline holds no result.
    `TVD_ASSERT_IMPL(a_reset_empty, !$past(i_rst_n), !m_axis_tvalid)
endmodule

bind tvd_slope_limiter tvd_checker u_tvd_checker (.*);
